[rtl/core/rsg_pkg.sv]
// rsg_pkg: shared widths, constants, tables and the pipeline control struct
// for the rotary sin/cos generator. No dependencies.
package rsg_pkg;

  localparam int unsigned POS_W    = 15;
  localparam int unsigned LANE_W   = 8;
  localparam int unsigned HW_W     = 9;
  localparam int unsigned LT_W     = 22;
  localparam int unsigned VAL_W    = 16;
  localparam int unsigned CFG_IW   = 2;
  localparam int unsigned CFG_DW   = 22;

  localparam int unsigned MAX_HEAD_WIDTH = 256;

  // exponent divider: 38-bit dividend, 30 quotient bits, 9-bit remainder
  localparam int unsigned NUM_W   = 38;
  localparam int unsigned QUO_W   = 30;
  localparam int unsigned REM_W   = 9;

  // exp2 fraction chain
  localparam int unsigned EXP_STEPS = 24;
  localparam int unsigned M_W       = 33;
  localparam int unsigned FAC_W     = 32;

  // trig datapath
  localparam int unsigned Q30_W        = 30;
  localparam int unsigned T_W          = 31;
  localparam int unsigned DIV_W        = 7;
  localparam int unsigned RCP_W        = 32;
  localparam int unsigned HORNER_STEPS = 4;

  localparam logic [T_W-1:0] Q30_ONE        = 31'h4000_0000;
  localparam logic [29:0]    INV_TWO_PI_Q32 = 30'd683565276;
  localparam logic [30:0]    HALF_PI_Q30    = 31'd1686629713;

  // configuration register indexes
  typedef enum logic [CFG_IW-1:0] {
    REG_HEAD_WIDTH   = 2'd0,
    REG_LOG2_THETA   = 2'd1,
    REG_THETA_POS    = 2'd2,
    REG_LAYOUT_VALID = 2'd3
  } cfg_reg_t;

  // control and sideband that travel with each transaction
  typedef struct packed {
    logic             valid;
    logic             fill;
    logic             want_cos;
    logic [POS_W-1:0] pos;
    logic [1:0]       quad;
    logic             swap;
    logic [Q30_W-1:0] y;
  } ctl_t;

  typedef logic [EXP_STEPS-1:0][FAC_W-1:0] factor_tab_t;

  // integer square root, evaluated at elaboration only
  function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
    logic [63:0] x;
    logic [63:0] res;
    logic [63:0] bit_v;
    x     = x_in;
    res   = 64'd0;
    bit_v = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (x >= res + bit_v) begin
        x   = x - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  // 2^(-2^-j) in Q0.32 for j = 1..24, by repeated square roots
  function automatic factor_tab_t make_factors();
    factor_tab_t f;
    logic [63:0] r;
    r    = isqrt64(64'd1 << 63);
    f[0] = r[FAC_W-1:0];
    for (int j = 1; j < EXP_STEPS; j++) begin
      r    = isqrt64({f[j-1], 32'd0});
      f[j] = r[FAC_W-1:0];
    end
    return f;
  endfunction

  localparam factor_tab_t ROOT_FACTOR = make_factors();

  // series divisors and their Q32 reciprocals, first step at index 0
  localparam logic [HORNER_STEPS-1:0][DIV_W-1:0] SIN_DIV = {7'd6, 7'd20, 7'd42, 7'd72};
  localparam logic [HORNER_STEPS-1:0][DIV_W-1:0] COS_DIV = {7'd2, 7'd12, 7'd30, 7'd56};
  localparam logic [HORNER_STEPS-1:0][RCP_W-1:0] SIN_RCP = {
    32'((64'd1 << 32) / 64'd6),  32'((64'd1 << 32) / 64'd20),
    32'((64'd1 << 32) / 64'd42), 32'((64'd1 << 32) / 64'd72)};
  localparam logic [HORNER_STEPS-1:0][RCP_W-1:0] COS_RCP = {
    32'((64'd1 << 32) / 64'd2),  32'((64'd1 << 32) / 64'd12),
    32'((64'd1 << 32) / 64'd30), 32'((64'd1 << 32) / 64'd56)};

endpackage

[rtl/core/rope_sin_cos_generator.sv]
// rope_sin_cos_generator: top level of the rotary embedding sin/cos generator.
// Depends on rsg_pkg, rsg_div_cell, rsg_exp_cell and rsg_horner_cell.
//
// Usage:
//   Input channel in_valid/in_stall carries position, lane and want_cosine;
//   a transaction is taken when in_valid is high and in_stall is low.
//   Result channel out_valid/out_stall carries one signed Q1.15 value per
//   input transaction, in order.
//   Configuration is a plain write port (cfg_we, cfg_index, cfg_wdata); the
//   user must write only while no transaction is in flight; not enforced.
// Throughput: one transaction per cycle unless out_stall holds the pipeline.
//   The datapath is a fixed pipeline: a 30-cell divider chain for the
//   exponent, a 24-cell exp2 chain, phase and octant stages, and a 4-cell
//   Horner chain of 3 stages each.
// Stalls: the whole pipeline holds on one enable; while a result waits in
//   the output register under out_stall, in_stall is raised and nothing moves.
// Reset: synchronous, active low; empties the pipeline and loads the default
//   configuration (head width 128, log2 theta 870828, theta and layout valid).
module rope_sin_cos_generator (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [rsg_pkg::POS_W-1:0]  in_position,
  input  logic [rsg_pkg::LANE_W-1:0] in_lane,
  input  logic                       in_want_cosine,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [rsg_pkg::VAL_W-1:0] out_value,
  input  logic                       cfg_we,
  input  logic [rsg_pkg::CFG_IW-1:0] cfg_index,
  input  logic [rsg_pkg::CFG_DW-1:0] cfg_wdata
);

  localparam int unsigned NDIV = rsg_pkg::QUO_W;
  localparam int unsigned NEXP = rsg_pkg::EXP_STEPS;
  localparam int unsigned NHRN = rsg_pkg::HORNER_STEPS;
  localparam int unsigned IW   = rsg_pkg::LANE_W + rsg_pkg::LT_W;
  localparam int unsigned AW   = rsg_pkg::POS_W + rsg_pkg::M_W;

  // to Q15 magnitude, rounded and saturated
  function automatic logic signed [rsg_pkg::VAL_W-1:0] to_q15(
    input logic [rsg_pkg::T_W-1:0] v);
    logic [rsg_pkg::T_W:0] r;
    r = (({1'b0, v}) + 32'd16384) >> 15;
    return (r > 32'd32767) ? 16'sd32767 : rsg_pkg::VAL_W'(r);
  endfunction

  logic en;

  // configuration registers
  logic [rsg_pkg::HW_W-1:0] head_width_r;
  logic [rsg_pkg::LT_W-1:0] log2_theta_r;
  logic                     theta_pos_r;
  logic                     layout_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_width_r   <= 9'd128;
      log2_theta_r   <= 22'd870828;
      theta_pos_r    <= 1'b1;
      layout_valid_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (rsg_pkg::cfg_reg_t'(cfg_index))
        rsg_pkg::REG_HEAD_WIDTH:   head_width_r   <= cfg_wdata[rsg_pkg::HW_W-1:0];
        rsg_pkg::REG_LOG2_THETA:   log2_theta_r   <= cfg_wdata;
        rsg_pkg::REG_THETA_POS:    theta_pos_r    <= cfg_wdata[0];
        rsg_pkg::REG_LAYOUT_VALID: layout_valid_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // global pipeline enable
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // front stage: special cases, half index, exponent numerator
  logic [rsg_pkg::LANE_W-1:0] half;
  logic [rsg_pkg::LANE_W-1:0] idx;
  logic                       fill;
  logic [IW-1:0]              num_prod;
  rsg_pkg::ctl_t              ctl_in;
  rsg_pkg::ctl_t              ctl_s0_r;
  logic [rsg_pkg::NUM_W-1:0]  num_s0_r;

  always_comb begin
    half     = head_width_r[rsg_pkg::HW_W-1:1];
    fill     = !layout_valid_r || !theta_pos_r || (half == '0) ||
               (head_width_r > rsg_pkg::HW_W'(rsg_pkg::MAX_HEAD_WIDTH)) ||
               ({1'b0, in_lane} >= {half, 1'b0});
    idx      = (in_lane < half) ? in_lane : in_lane - half;
    num_prod = IW'(idx) * IW'(log2_theta_r);
    ctl_in          = '0;
    ctl_in.valid    = in_valid;
    ctl_in.fill     = fill;
    ctl_in.want_cos = in_want_cosine;
    ctl_in.pos      = in_position;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_s0_r <= '0;
    end else if (en) begin
      ctl_s0_r <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_s0_r <= {num_prod[rsg_pkg::NUM_W-10:0], 9'd0};
    end
  end

  // divider chain: e = numerator / head width, one bit per cell
  rsg_pkg::ctl_t             ctl_div [NDIV+1];
  logic [rsg_pkg::REM_W-1:0] rem_div [NDIV+1];
  logic [rsg_pkg::QUO_W-1:0] num_div [NDIV+1];

  assign ctl_div[0] = ctl_s0_r;
  assign rem_div[0] = {1'b0, num_s0_r[rsg_pkg::NUM_W-1:rsg_pkg::QUO_W]};
  assign num_div[0] = num_s0_r[rsg_pkg::QUO_W-1:0];

  for (genvar k = 0; k < NDIV; k++) begin : g_div
    rsg_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .ctl_i     (ctl_div[k]),
      .rem_i     (rem_div[k]),
      .num_i     (num_div[k]),
      .divisor_i (head_width_r),
      .ctl_o     (ctl_div[k+1]),
      .rem_o     (rem_div[k+1]),
      .num_o     (num_div[k+1])
    );
  end

  // exp2 chain over the 24 fraction bits of e
  rsg_pkg::ctl_t             ctl_exp [NEXP+1];
  logic [rsg_pkg::M_W-1:0]   m_exp   [NEXP+1];
  logic [rsg_pkg::QUO_W-1:0] e_exp   [NEXP+1];

  assign ctl_exp[0] = ctl_div[NDIV];
  assign m_exp[0]   = rsg_pkg::M_W'(1) << 32;
  assign e_exp[0]   = num_div[NDIV];

  for (genvar k = 0; k < NEXP; k++) begin : g_exp
    rsg_exp_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .ctl_i    (ctl_exp[k]),
      .m_i      (m_exp[k]),
      .e_i      (e_exp[k]),
      .sel_i    (e_exp[k][NEXP-1-k]),
      .factor_i (rsg_pkg::ROOT_FACTOR[k]),
      .ctl_o    (ctl_exp[k+1]),
      .m_o      (m_exp[k+1]),
      .e_o      (e_exp[k+1])
    );
  end

  // frequency, angle and phase stages
  rsg_pkg::ctl_t           ctl_f1_r;
  rsg_pkg::ctl_t           ctl_f2_r;
  rsg_pkg::ctl_t           ctl_p1_r;
  rsg_pkg::ctl_t           ctl_p2_r;
  logic [rsg_pkg::M_W-1:0] freq_r;
  logic [AW-1:0]           ang_r;
  logic [31:0]             hi_r;
  logic [29:0]             lo_r;
  logic [31:0]             phase_r;
  logic [45:0]             hi_full;
  logic [61:0]             lo_full;

  always_comb begin
    hi_full = 46'(ang_r[AW-1:32]) * 46'(rsg_pkg::INV_TWO_PI_Q32);
    lo_full = 62'(ang_r[31:0]) * 62'(rsg_pkg::INV_TWO_PI_Q32);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_f1_r <= '0;
      ctl_f2_r <= '0;
      ctl_p1_r <= '0;
      ctl_p2_r <= '0;
    end else if (en) begin
      ctl_f1_r <= ctl_exp[NEXP];
      ctl_f2_r <= ctl_f1_r;
      ctl_p1_r <= ctl_f2_r;
      ctl_p2_r <= ctl_p1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      freq_r  <= m_exp[NEXP] >> e_exp[NEXP][rsg_pkg::QUO_W-1:24];
      ang_r   <= AW'(ctl_f1_r.pos) * AW'(freq_r);
      hi_r    <= hi_full[31:0];
      lo_r    <= lo_full[61:32];
      phase_r <= hi_r + {2'b00, lo_r};
    end
  end

  // octant reduction, y and y squared
  logic [29:0]               frac;
  logic                      fold;
  logic [29:0]               g_val;
  logic [60:0]               y_full;
  logic [59:0]               y2_full;
  rsg_pkg::ctl_t             ctl_o1_nxt;
  rsg_pkg::ctl_t             ctl_o1_r;
  rsg_pkg::ctl_t             ctl_o2_r;
  logic [rsg_pkg::Q30_W-1:0] y2_r;

  always_comb begin
    frac    = phase_r[29:0];
    fold    = frac > 30'h2000_0000;
    g_val   = fold ? 30'(31'h4000_0000 - {1'b0, frac}) : frac;
    y_full  = 61'(g_val) * 61'(rsg_pkg::HALF_PI_Q30);
    y2_full = 60'(ctl_o1_r.y) * 60'(ctl_o1_r.y);
    ctl_o1_nxt      = ctl_p2_r;
    ctl_o1_nxt.quad = phase_r[31:30];
    ctl_o1_nxt.swap = fold;
    ctl_o1_nxt.y    = y_full[59:30];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_o1_r <= '0;
      ctl_o2_r <= '0;
    end else if (en) begin
      ctl_o1_r <= ctl_o1_nxt;
      ctl_o2_r <= ctl_o1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y2_r <= y2_full[59:30];
    end
  end

  // Horner chain for both series
  rsg_pkg::ctl_t             ctl_hr [NHRN+1];
  logic [rsg_pkg::Q30_W-1:0] y2_hr  [NHRN+1];
  logic [rsg_pkg::T_W-1:0]   ts_hr  [NHRN+1];
  logic [rsg_pkg::T_W-1:0]   tc_hr  [NHRN+1];

  assign ctl_hr[0] = ctl_o2_r;
  assign y2_hr[0]  = y2_r;
  assign ts_hr[0]  = rsg_pkg::Q30_ONE;
  assign tc_hr[0]  = rsg_pkg::Q30_ONE;

  for (genvar k = 0; k < NHRN; k++) begin : g_hrn
    rsg_horner_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .ctl_i (ctl_hr[k]),
      .y2_i  (y2_hr[k]),
      .ts_i  (ts_hr[k]),
      .tc_i  (tc_hr[k]),
      .ds_i  (rsg_pkg::SIN_DIV[k]),
      .rs_i  (rsg_pkg::SIN_RCP[k]),
      .dc_i  (rsg_pkg::COS_DIV[k]),
      .rc_i  (rsg_pkg::COS_RCP[k]),
      .ctl_o (ctl_hr[k+1]),
      .y2_o  (y2_hr[k+1]),
      .ts_o  (ts_hr[k+1]),
      .tc_o  (tc_hr[k+1])
    );
  end

  // sine = y * t, then quadrant fix-up into the output register
  logic [60:0]                     s_full;
  rsg_pkg::ctl_t                   ctl_t1_r;
  rsg_pkg::ctl_t                   ctl_out_r;
  logic [rsg_pkg::T_W-1:0]         sin_r;
  logic [rsg_pkg::T_W-1:0]         cos_r;
  logic [rsg_pkg::T_W-1:0]         sin_sw;
  logic [rsg_pkg::T_W-1:0]         cos_sw;
  logic signed [rsg_pkg::VAL_W-1:0] s_mag;
  logic signed [rsg_pkg::VAL_W-1:0] c_mag;
  logic signed [rsg_pkg::VAL_W-1:0] sv;
  logic signed [rsg_pkg::VAL_W-1:0] cv;
  logic signed [rsg_pkg::VAL_W-1:0] value_nxt;
  logic signed [rsg_pkg::VAL_W-1:0] out_value_r;
  logic                            out_valid_r;

  always_comb begin
    s_full = 61'(ctl_hr[NHRN].y) * 61'(ts_hr[NHRN]);
  end

  always_comb begin
    sin_sw = ctl_t1_r.swap ? cos_r : sin_r;
    cos_sw = ctl_t1_r.swap ? sin_r : cos_r;
    s_mag  = to_q15(sin_sw);
    c_mag  = to_q15(cos_sw);
    unique case (ctl_t1_r.quad)
      2'd0: begin sv = s_mag;  cv = c_mag;  end
      2'd1: begin sv = c_mag;  cv = -s_mag; end
      2'd2: begin sv = -s_mag; cv = -c_mag; end
      default: begin sv = -c_mag; cv = s_mag; end
    endcase
    if (ctl_t1_r.fill) begin
      value_nxt = ctl_t1_r.want_cos ? 16'sd32767 : 16'sd0;
    end else begin
      value_nxt = ctl_t1_r.want_cos ? cv : sv;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_t1_r    <= '0;
      ctl_out_r   <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      ctl_t1_r    <= ctl_hr[NHRN];
      ctl_out_r   <= ctl_t1_r;
      out_valid_r <= ctl_t1_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_r       <= {1'b0, s_full[59:30]};
      cos_r       <= tc_hr[NHRN];
      out_value_r <= value_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

`ifndef SYNTHESIS
  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // special-case items give the fill value
  a_fill_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ctl_out_r.fill) |->
      (out_value == (ctl_out_r.want_cos ? 16'sd32767 : 16'sd0)))
    else $error("fill value wrong");

  // saturation keeps the result symmetric
  a_no_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_value != -16'sd32768))
    else $error("result reached -1.0");

  // a held pipeline does not move
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> ($stable(ctl_o2_r) && $stable(y2_r)))
    else $error("pipeline moved under stall");
`endif

endmodule

[rtl/core/rsg_div_cell.sv]
// rsg_div_cell: one restoring-division cell, produces one quotient bit.
// Depends on rsg_pkg.
module rsg_div_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  rsg_pkg::ctl_t             ctl_i,
  input  logic [rsg_pkg::REM_W-1:0] rem_i,
  input  logic [rsg_pkg::QUO_W-1:0] num_i,
  input  logic [rsg_pkg::HW_W-1:0]  divisor_i,
  output rsg_pkg::ctl_t             ctl_o,
  output logic [rsg_pkg::REM_W-1:0] rem_o,
  output logic [rsg_pkg::QUO_W-1:0] num_o
);

  logic [rsg_pkg::REM_W:0]   trial;
  logic                      take;
  logic [rsg_pkg::REM_W-1:0] rem_nxt;
  logic [rsg_pkg::QUO_W-1:0] num_nxt;
  rsg_pkg::ctl_t             ctl_r;
  logic [rsg_pkg::REM_W-1:0] rem_r;
  logic [rsg_pkg::QUO_W-1:0] num_r;

  // shift in next dividend bit, subtract when it fits
  always_comb begin
    trial   = {rem_i, num_i[rsg_pkg::QUO_W-1]};
    take    = trial >= {1'b0, divisor_i};
    rem_nxt = take ? rsg_pkg::REM_W'(trial - {1'b0, divisor_i})
                   : trial[rsg_pkg::REM_W-1:0];
    num_nxt = {num_i[rsg_pkg::QUO_W-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      num_r <= num_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign rem_o = rem_r;
  assign num_o = num_r;

endmodule

[rtl/core/rsg_exp_cell.sv]
// rsg_exp_cell: one step of the exp2 fraction chain, multiplies in a root
// factor when its exponent bit is set. Depends on rsg_pkg.
module rsg_exp_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  rsg_pkg::ctl_t             ctl_i,
  input  logic [rsg_pkg::M_W-1:0]   m_i,
  input  logic [rsg_pkg::QUO_W-1:0] e_i,
  input  logic                      sel_i,
  input  logic [rsg_pkg::FAC_W-1:0] factor_i,
  output rsg_pkg::ctl_t             ctl_o,
  output logic [rsg_pkg::M_W-1:0]   m_o,
  output logic [rsg_pkg::QUO_W-1:0] e_o
);

  localparam int unsigned PW = rsg_pkg::M_W + rsg_pkg::FAC_W;

  logic [PW-1:0]             prod;
  logic [rsg_pkg::M_W-1:0]   m_nxt;
  rsg_pkg::ctl_t             ctl_r;
  logic [rsg_pkg::M_W-1:0]   m_r;
  logic [rsg_pkg::QUO_W-1:0] e_r;

  // rounded Q1.32 product
  always_comb begin
    prod  = PW'(m_i) * PW'(factor_i) + (PW'(1) << 31);
    m_nxt = sel_i ? rsg_pkg::M_W'(prod >> 32) : m_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r <= m_nxt;
      e_r <= e_i;
    end
  end

  assign ctl_o = ctl_r;
  assign m_o   = m_r;
  assign e_o   = e_r;

endmodule

[rtl/core/rsg_horner_cell.sv]
// rsg_horner_cell: one Horner step of the sine and cosine series, three
// stages: multiply, reciprocal multiply, correct and subtract. Depends on rsg_pkg.
module rsg_horner_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  rsg_pkg::ctl_t             ctl_i,
  input  logic [rsg_pkg::Q30_W-1:0] y2_i,
  input  logic [rsg_pkg::T_W-1:0]   ts_i,
  input  logic [rsg_pkg::T_W-1:0]   tc_i,
  input  logic [rsg_pkg::DIV_W-1:0] ds_i,
  input  logic [rsg_pkg::RCP_W-1:0] rs_i,
  input  logic [rsg_pkg::DIV_W-1:0] dc_i,
  input  logic [rsg_pkg::RCP_W-1:0] rc_i,
  output rsg_pkg::ctl_t             ctl_o,
  output logic [rsg_pkg::Q30_W-1:0] y2_o,
  output logic [rsg_pkg::T_W-1:0]   ts_o,
  output logic [rsg_pkg::T_W-1:0]   tc_o
);

  localparam int unsigned MW = rsg_pkg::Q30_W + rsg_pkg::T_W;
  localparam int unsigned RW = rsg_pkg::Q30_W + rsg_pkg::RCP_W;
  localparam int unsigned CW = rsg_pkg::Q30_W + rsg_pkg::DIV_W;

  logic [MW-1:0]             mul_s;
  logic [MW-1:0]             mul_c;
  logic [RW-1:0]             est_s;
  logic [RW-1:0]             est_c;
  logic [rsg_pkg::Q30_W-1:0] q0_s;
  logic [rsg_pkg::Q30_W-1:0] q0_c;
  logic [CW-1:0]             back_s;
  logic [CW-1:0]             back_c;
  logic [rsg_pkg::Q30_W-1:0] rem_s;
  logic [rsg_pkg::Q30_W-1:0] rem_c;
  logic [rsg_pkg::Q30_W-1:0] quo_s;
  logic [rsg_pkg::Q30_W-1:0] quo_c;

  rsg_pkg::ctl_t             ctl_a_r;
  rsg_pkg::ctl_t             ctl_b_r;
  rsg_pkg::ctl_t             ctl_c_r;
  logic [rsg_pkg::Q30_W-1:0] y2_a_r;
  logic [rsg_pkg::Q30_W-1:0] y2_b_r;
  logic [rsg_pkg::Q30_W-1:0] y2_c_r;
  logic [rsg_pkg::Q30_W-1:0] ps_a_r;
  logic [rsg_pkg::Q30_W-1:0] pc_a_r;
  logic [rsg_pkg::Q30_W-1:0] ps_b_r;
  logic [rsg_pkg::Q30_W-1:0] pc_b_r;
  logic [RW-1:0]             es_b_r;
  logic [RW-1:0]             ec_b_r;
  logic [rsg_pkg::T_W-1:0]   ts_c_r;
  logic [rsg_pkg::T_W-1:0]   tc_c_r;

  // stage a: Q30 products with y squared
  always_comb begin
    mul_s = MW'(y2_i) * MW'(ts_i);
    mul_c = MW'(y2_i) * MW'(tc_i);
  end

  // stage b: quotient estimate by reciprocal
  always_comb begin
    est_s = RW'(ps_a_r) * RW'(rs_i);
    est_c = RW'(pc_a_r) * RW'(rc_i);
  end

  // stage c: estimate is low by at most one, fix it up
  always_comb begin
    q0_s   = es_b_r[RW-1:32];
    q0_c   = ec_b_r[RW-1:32];
    back_s = CW'(q0_s) * CW'(ds_i);
    back_c = CW'(q0_c) * CW'(dc_i);
    rem_s  = ps_b_r - back_s[rsg_pkg::Q30_W-1:0];
    rem_c  = pc_b_r - back_c[rsg_pkg::Q30_W-1:0];
    quo_s  = q0_s + rsg_pkg::Q30_W'(rem_s >= rsg_pkg::Q30_W'(ds_i));
    quo_c  = q0_c + rsg_pkg::Q30_W'(rem_c >= rsg_pkg::Q30_W'(dc_i));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r <= '0;
      ctl_b_r <= '0;
      ctl_c_r <= '0;
    end else if (en) begin
      ctl_a_r <= ctl_i;
      ctl_b_r <= ctl_a_r;
      ctl_c_r <= ctl_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y2_a_r <= y2_i;
      ps_a_r <= mul_s[MW-2:30];
      pc_a_r <= mul_c[MW-2:30];
      y2_b_r <= y2_a_r;
      ps_b_r <= ps_a_r;
      pc_b_r <= pc_a_r;
      es_b_r <= est_s;
      ec_b_r <= est_c;
      y2_c_r <= y2_b_r;
      ts_c_r <= rsg_pkg::Q30_ONE - rsg_pkg::T_W'(quo_s);
      tc_c_r <= rsg_pkg::Q30_ONE - rsg_pkg::T_W'(quo_c);
    end
  end

  assign ctl_o = ctl_c_r;
  assign y2_o  = y2_c_r;
  assign ts_o  = ts_c_r;
  assign tc_o  = tc_c_r;

endmodule
